[hdl/met_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths, reset values and helpers for the escape-time pixel block.
// No dependencies; every other file refers to it by scoped names.
package met_pkg;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 28;
    localparam int WORD_BITS  = 32;
    localparam int COUNT_BITS = 12;
    localparam int COLOR_BITS = 8;
    localparam int GREEN_BITS = 6;
    localparam int BLUE_BITS  = 7;
    localparam int CFG_INDEX_BITS = 3;

    // Wide intermediate for sums that still need a shift and a clamp.
    localparam int WIDE_BITS =
        (WORD_BITS + FRAC_BITS + 3 > 2 * WORD_BITS + 2) ?
        (WORD_BITS + FRAC_BITS + 3) : (2 * WORD_BITS + 2);
    // Width of |z|^2 and of the radius bound 4.0 at twice the fraction bits.
    localparam int SUM_BITS =
        (2 * FRAC_BITS + 3 > 2 * WORD_BITS) ? (2 * FRAC_BITS + 3) : (2 * WORD_BITS);
    localparam int PROD_BITS = COORD_BITS + 1 + WORD_BITS;
    localparam int DIV_BITS  = COUNT_BITS + COLOR_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [COUNT_BITS-1:0]       count_t;
    typedef logic [COLOR_BITS-1:0]       color_t;

    localparam logic [SUM_BITS-1:0] RADIUS_BOUND = SUM_BITS'(4) << (2 * FRAC_BITS);

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_REAL_START = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_REAL_STEP  = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAG_START = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAG_STEP  = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIMIT = CFG_INDEX_BITS'(4);

    localparam word_t  RESET_REAL_START = -32'sd657666867;
    localparam word_t  RESET_REAL_STEP  = 32'sd489335;
    localparam word_t  RESET_IMAG_START = -32'sd268435456;
    localparam word_t  RESET_IMAG_STEP  = 32'sd497103;
    localparam count_t RESET_ITER_LIMIT = COUNT_BITS'(100);

    // Command and status between the top level and the iteration core.
    typedef struct packed {
        logic   go;
        word_t  cr;
        word_t  ci;
        count_t limit;
    } iter_cmd_t;

    typedef struct packed {
        logic   done;
        count_t count;
    } iter_stat_t;

    // Word handed from one divider cell to the next.
    typedef struct packed {
        logic                valid;
        logic [DIV_BITS-1:0] rem;
        logic [DIV_BITS-1:0] dvs;
        color_t              quo;
    } div_word_t;

    // Clamp a wide signed value to the word range.
    function automatic word_t sat_word(input logic signed [WIDE_BITS-1:0] v);
        logic [WIDE_BITS-WORD_BITS:0] top;
        top = v[WIDE_BITS-1:WORD_BITS-1];
        if ((&top) || (~|top))
            return v[WORD_BITS-1:0];
        else if (v[WIDE_BITS-1])
            return {1'b1, {(WORD_BITS-1){1'b0}}};
        else
            return {1'b0, {(WORD_BITS-1){1'b1}}};
    endfunction

endpackage

[hdl/met_div_cell.sv]
`timescale 1ns / 1ps
// One restoring-division cell: decides one quotient bit and hands the word on.
// Depends on met_pkg.
module met_div_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  met_pkg::div_word_t  w_in,
    output met_pkg::div_word_t  w_out
);

    met_pkg::div_word_t w_reg;
    met_pkg::div_word_t w_next;
    logic               fits;

    always_comb
    begin
        fits         = (w_in.rem >= w_in.dvs);
        w_next.valid = w_in.valid;
        w_next.rem   = fits ? (w_in.rem - w_in.dvs) : w_in.rem;
        w_next.dvs   = w_in.dvs >> 1;
        w_next.quo   = {w_in.quo[met_pkg::COLOR_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
        end
        else
        begin
            w_reg <= w_next;
        end
    end

    assign w_out = w_reg;

endmodule

[hdl/met_core.sv]
`timescale 1ns / 1ps
// Iteration core: z = z*z + c from zero until escape or the iteration limit.
// Each iteration runs a multiply state, then an add/test/clamp state. Depends on met_pkg.
module met_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  met_pkg::iter_cmd_t  cmd,
    output met_pkg::iter_stat_t stat
);

    typedef enum logic [1:0] {CORE_IDLE, CORE_MUL, CORE_UPD} core_state_t;

    core_state_t                          state_reg;
    met_pkg::word_t                       x_reg;
    met_pkg::word_t                       y_reg;
    met_pkg::count_t                      count_reg;
    logic                                 done_reg;
    logic signed [2*met_pkg::WORD_BITS-1:0] xx_reg;
    logic signed [2*met_pkg::WORD_BITS-1:0] yy_reg;
    logic signed [2*met_pkg::WORD_BITS-1:0] xy_reg;

    logic [met_pkg::SUM_BITS-1:0]         radius_sq;
    logic                                 stop;
    logic signed [met_pkg::WIDE_BITS-1:0] xw;
    logic signed [met_pkg::WIDE_BITS-1:0] yw;
    met_pkg::word_t                       x_next;
    met_pkg::word_t                       y_next;

    always_comb
    begin
        // Squares are never negative: zero-extend for the radius test.
        radius_sq = met_pkg::SUM_BITS'($unsigned(xx_reg))
                  + met_pkg::SUM_BITS'($unsigned(yy_reg));
        stop = (radius_sq > met_pkg::RADIUS_BOUND) || (count_reg >= cmd.limit);
        // Fold c in before the floor shift: floor(a/2^f) + c == floor((a + c*2^f)/2^f).
        xw = met_pkg::WIDE_BITS'(xx_reg) - met_pkg::WIDE_BITS'(yy_reg)
           + (met_pkg::WIDE_BITS'(cmd.cr) <<< met_pkg::FRAC_BITS);
        yw = met_pkg::WIDE_BITS'(xy_reg)
           + (met_pkg::WIDE_BITS'(cmd.ci) <<< (met_pkg::FRAC_BITS - 1));
        x_next = met_pkg::sat_word(xw >>> met_pkg::FRAC_BITS);
        y_next = met_pkg::sat_word(yw >>> (met_pkg::FRAC_BITS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            xx_reg    <= '0;
            yy_reg    <= '0;
            xy_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                CORE_IDLE:
                begin
                    if (cmd.go)
                    begin
                        x_reg     <= '0;
                        y_reg     <= '0;
                        count_reg <= '0;
                        state_reg <= CORE_MUL;
                    end
                end
                CORE_MUL:
                begin
                    xx_reg    <= x_reg * x_reg;
                    yy_reg    <= y_reg * y_reg;
                    xy_reg    <= x_reg * y_reg;
                    state_reg <= CORE_UPD;
                end
                CORE_UPD:
                begin
                    if (stop)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= CORE_IDLE;
                    end
                    else
                    begin
                        x_reg     <= x_next;
                        y_reg     <= y_next;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= CORE_MUL;
                    end
                end
                default:
                begin
                    state_reg <= CORE_IDLE;
                end
            endcase
        end
    end

    assign stat.done  = done_reg;
    assign stat.count = count_reg;

endmodule

[hdl/mandelbrot_escape_time_pixel.sv]
`timescale 1ns / 1ps
// Top level of the escape-time pixel block: coordinate mapping, iteration core,
// colour divider chain. Depends on met_pkg, met_core and met_div_cell.
//
// Usage:
//   Input channel: drive column/row and raise start; the word is taken at a
//   rising edge where start is high and busy is low. One pixel is in flight
//   at a time; busy stays high until its result has been issued.
//   Output channel: done is high for exactly one cycle with iteration_count,
//   red, green and blue valid in that cycle. The receiver cannot stall, so
//   capture the word when done is seen.
//   Configuration: cfg_we/cfg_index/cfg_data write one register per edge;
//   index 0..4 = real_start, real_step, imag_start, imag_step,
//   iteration_limit. Other indexes are ignored. Write only while idle.
// Timing: the time from accept to done grows with the iteration count. For
//   each iteration the single core spends one state on the three 32x32
//   products and one on the add, radius test and clamp. The colour quotient
//   then runs through an eight-cell divider chain.
// Reset: asynchronous, active low; registers return to their default view,
//   no pixel is in flight and done is low.
module mandelbrot_escape_time_pixel
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [met_pkg::COORD_BITS-1:0]        column,
    input  logic [met_pkg::COORD_BITS-1:0]        row,
    output logic                                  done,
    output logic [met_pkg::COUNT_BITS-1:0]        iteration_count,
    output logic [met_pkg::COLOR_BITS-1:0]        red,
    output logic [met_pkg::GREEN_BITS-1:0]        green,
    output logic [met_pkg::BLUE_BITS-1:0]         blue,
    input  logic                                  cfg_we,
    input  logic [met_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [met_pkg::WORD_BITS-1:0]         cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_MAP, ST_ITER, ST_DIV} top_state_t;

    localparam int LAST_CELL = met_pkg::COLOR_BITS;

    // Configuration registers.
    met_pkg::word_t  real_start_reg;
    met_pkg::word_t  real_step_reg;
    met_pkg::word_t  imag_start_reg;
    met_pkg::word_t  imag_step_reg;
    met_pkg::count_t limit_reg;

    top_state_t      state_reg;
    logic signed [met_pkg::PROD_BITS-1:0] prod_re_reg;
    logic signed [met_pkg::PROD_BITS-1:0] prod_im_reg;
    met_pkg::word_t  cr_reg;
    met_pkg::word_t  ci_reg;
    logic            go_reg;
    met_pkg::count_t count_reg;
    met_pkg::div_word_t div_in_reg;

    logic            done_reg;
    met_pkg::count_t count_out_reg;
    met_pkg::color_t red_reg;

    met_pkg::iter_cmd_t  cmd;
    met_pkg::iter_stat_t stat;
    met_pkg::div_word_t  chain [LAST_CELL+1];

    met_pkg::word_t  cr_next;
    met_pkg::word_t  ci_next;
    met_pkg::color_t red_next;

    // Configuration writes; unknown indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_start_reg <= met_pkg::RESET_REAL_START;
            real_step_reg  <= met_pkg::RESET_REAL_STEP;
            imag_start_reg <= met_pkg::RESET_IMAG_START;
            imag_step_reg  <= met_pkg::RESET_IMAG_STEP;
            limit_reg      <= met_pkg::RESET_ITER_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                met_pkg::REG_REAL_START: real_start_reg <= cfg_data;
                met_pkg::REG_REAL_STEP:  real_step_reg  <= cfg_data;
                met_pkg::REG_IMAG_START: imag_start_reg <= cfg_data;
                met_pkg::REG_IMAG_STEP:  imag_step_reg  <= cfg_data;
                met_pkg::REG_ITER_LIMIT: limit_reg      <= cfg_data[met_pkg::COUNT_BITS-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        // c = start + index*step, clamped to the word range.
        cr_next = met_pkg::sat_word(met_pkg::WIDE_BITS'(real_start_reg)
                                  + met_pkg::WIDE_BITS'(prod_re_reg));
        ci_next = met_pkg::sat_word(met_pkg::WIDE_BITS'(imag_start_reg)
                                  + met_pkg::WIDE_BITS'(prod_im_reg));
        // Points that hit the limit are black.
        red_next = (count_reg < limit_reg) ? chain[LAST_CELL].quo : '0;
    end

    // Main sequencer and output word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prod_re_reg   <= '0;
            prod_im_reg   <= '0;
            cr_reg        <= '0;
            ci_reg        <= '0;
            go_reg        <= 1'b0;
            count_reg     <= '0;
            div_in_reg    <= '0;
            done_reg      <= 1'b0;
            count_out_reg <= '0;
            red_reg       <= '0;
        end
        else
        begin
            go_reg           <= 1'b0;
            div_in_reg.valid <= 1'b0;
            done_reg         <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        // Index is unsigned: prepend a zero before the signed multiply.
                        prod_re_reg <= $signed({1'b0, column}) * real_step_reg;
                        prod_im_reg <= $signed({1'b0, row}) * imag_step_reg;
                        state_reg   <= ST_MAP;
                    end
                end
                ST_MAP:
                begin
                    cr_reg    <= cr_next;
                    ci_reg    <= ci_next;
                    go_reg    <= 1'b1;
                    state_reg <= ST_ITER;
                end
                ST_ITER:
                begin
                    if (stat.done)
                    begin
                        // Launch 255*count / limit down the divider chain.
                        count_reg        <= stat.count;
                        div_in_reg.valid <= 1'b1;
                        div_in_reg.rem   <= met_pkg::DIV_BITS'({stat.count,
                                                met_pkg::COLOR_BITS'(0)})
                                          - met_pkg::DIV_BITS'(stat.count);
                        div_in_reg.dvs   <= met_pkg::DIV_BITS'(limit_reg)
                                          << (met_pkg::COLOR_BITS - 1);
                        div_in_reg.quo   <= '0;
                        state_reg        <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (chain[LAST_CELL].valid)
                    begin
                        done_reg      <= 1'b1;
                        count_out_reg <= count_reg;
                        red_reg       <= red_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cmd.go    = go_reg;
    assign cmd.cr    = cr_reg;
    assign cmd.ci    = ci_reg;
    assign cmd.limit = limit_reg;

    met_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Divider chain: each cell settles one quotient bit, MSB first.
    assign chain[0] = div_in_reg;

    for (genvar i = 0; i < LAST_CELL; i++)
    begin : g_div
        met_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .w_in  (chain[i]),
            .w_out (chain[i+1])
        );
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign iteration_count = count_out_reg;
    assign red             = red_reg;
    assign green           = red_reg[met_pkg::COLOR_BITS-1:2];
    assign blue            = red_reg[met_pkg::COLOR_BITS-1:1];

endmodule

[hdl/met_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the escape-time pixel block, bound to the top level.
// Depends on met_pkg and mandelbrot_escape_time_pixel.
module met_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [met_pkg::COLOR_BITS-1:0]    red,
    input logic [met_pkg::GREEN_BITS-1:0]    green,
    input logic [met_pkg::BLUE_BITS-1:0]     blue
);

    // An accepted word keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // The result goes out as the block frees up, never during work.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done seen while busy");

    // One result per word: the strobe always drops again after it rises.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Green and blue follow red.
    a_color_shape: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (green == red[met_pkg::COLOR_BITS-1:2]) &&
                 (blue == red[met_pkg::COLOR_BITS-1:1]))
        else $error("green or blue not derived from red");

    // Busy only rises on an accepted word.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .red   (red),
    .green (green),
    .blue  (blue)
);
